FILE: src/key_frequency_table_core_defines.svh
// Assertion helpers for the key frequency table.
`ifndef KEY_FREQUENCY_TABLE_CORE_DEFINES_SVH
`define KEY_FREQUENCY_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KFT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kft check failed");

// Next-cycle implication, checked out of reset.
`define KFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kft check failed");

`endif

FILE: src/kft_pkg.sv
`timescale 1ns / 1ps
package kft_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 16;

    localparam logic [1:0] ACT_COUNT = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_DUMP  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic load;   // latch the accepted item
        logic exec;   // run a count, query or dump start
        logic step;   // emit one dump entry and rotate the chain
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic is_dump;
        logic used_zero;
        logic dump_last;
        logic used_over;
    } t_sts;

endpackage

FILE: src/key_frequency_table_core.sv
`timescale 1ns / 1ps
// Count and query items: the item is latched on accept, and its result is registered
// in S_EXEC once no result is held off (one compare across the whole cell chain); the
// next item is taken once the block is back in S_IDLE. Dump items: one entry per cycle
// off the head of the chain as it rotates back into order, while no result is held off.
// Reset (i_rst_n low, synchronous) empties the table and drops any pending result.
`include "key_frequency_table_core_defines.svh"
module key_frequency_table_core #(
    parameter int ENTRIES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_action,
    input  logic signed [kft_pkg::KEY_W-1:0] i_key,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [kft_pkg::KEY_W-1:0] o_out_key,
    output logic [kft_pkg::COUNT_W-1:0]      o_count,
    output logic [1:0]                       o_status,
    output logic                             o_last
);

    kft_pkg::t_cmd cmd;
    kft_pkg::t_sts sts;

    kft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    kft_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_action  (i_action),
        .i_key     (i_key),
        .i_stall   (i_stall),
        .o_sts     (sts),
        .o_valid   (o_valid),
        .o_out_key (o_out_key),
        .o_count   (o_count),
        .o_status  (o_status),
        .o_last    (o_last)
    );

    `KFT_ASSERT_NOW(a_used_bound, 1'b1, !sts.used_over)
    `KFT_ASSERT_NOW(a_mid_dump_ok, o_valid && !o_last, o_status == kft_pkg::ST_OK)
    `KFT_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    `KFT_ASSERT_NOW(a_one_cmd, 1'b1, !(cmd.exec && cmd.step))

endmodule

FILE: src/kft_ctrl.sv
`timescale 1ns / 1ps
module kft_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  kft_pkg::t_sts i_sts,
    output logic          o_stall,
    output kft_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } t_state;

    t_state r_state, n_state;
    logic   r_stall;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.load = i_valid && !r_stall;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_sts.is_dump && !i_sts.used_zero) begin
                        n_state = S_DUMP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DUMP: begin
                if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_stall = r_stall;

endmodule

FILE: src/kft_datapath.sv
`timescale 1ns / 1ps
module kft_datapath #(
    parameter int ENTRIES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  kft_pkg::t_cmd                       i_cmd,
    input  logic [1:0]                          i_action,
    input  logic signed [kft_pkg::KEY_W-1:0]    i_key,
    input  logic                                i_stall,
    output kft_pkg::t_sts                       o_sts,
    output logic                                o_valid,
    output logic signed [kft_pkg::KEY_W-1:0]    o_out_key,
    output logic [kft_pkg::COUNT_W-1:0]         o_count,
    output logic [1:0]                          o_status,
    output logic                                o_last
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    // sorted cell chain, cells below r_used hold entries
    logic signed [kft_pkg::KEY_W-1:0] r_keys   [ENTRIES];
    logic [kft_pkg::COUNT_W-1:0]      r_counts [ENTRIES];
    logic signed [kft_pkg::KEY_W-1:0] n_keys   [ENTRIES];
    logic [kft_pkg::COUNT_W-1:0]      n_counts [ENTRIES];
    logic [CW-1:0]                    r_used, n_used;
    logic [CW-1:0]                    r_idx;
    logic [1:0]                       r_act;
    logic signed [kft_pkg::KEY_W-1:0] r_key;

    logic r_ov;
    logic signed [kft_pkg::KEY_W-1:0] r_okey;
    logic [kft_pkg::COUNT_W-1:0]      r_ocnt;
    logic [1:0]                       r_ost;
    logic                             r_olast;

    logic [ENTRIES-1:0]          lt, eq, ins_here;
    logic                        hit;
    logic [kft_pkg::COUNT_W-1:0] hit_cnt, inc_cnt;
    logic [CW-1:0]               last_idx;
    logic                        out_free;

    assign last_idx = r_used - 1'b1;
    assign out_free = !r_ov || !i_stall;

    // per-cell compare against the latched key
    always_comb begin
        hit_cnt = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            lt[i]   = (CW'(i) < r_used) && (r_keys[i] < r_key);
            eq[i]   = (CW'(i) < r_used) && (r_keys[i] == r_key);
            hit_cnt = hit_cnt | (eq[i] ? r_counts[i] : '0);
        end
        ins_here[0] = !lt[0];
        for (int i = 1; i < ENTRIES; i++) begin
            ins_here[i] = !lt[i] && lt[i-1];
        end
        hit     = |eq;
        inc_cnt = (hit_cnt == '1) ? hit_cnt : hit_cnt + 1'b1;
    end

    always_comb begin
        n_used = r_used;
        for (int i = 0; i < ENTRIES; i++) begin
            n_keys[i]   = r_keys[i];
            n_counts[i] = r_counts[i];
        end
        if (i_cmd.exec && r_act == kft_pkg::ACT_COUNT) begin
            if (hit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (eq[i]) begin
                        n_counts[i] = inc_cnt;
                    end
                end
            end else if (r_used != FULL) begin
                n_used = r_used + 1'b1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (ins_here[i]) begin
                        n_keys[i]   = r_key;
                        n_counts[i] = kft_pkg::COUNT_W'(1);
                    end else if (!lt[i] && i > 0) begin
                        n_keys[i]   = r_keys[i-1];
                        n_counts[i] = r_counts[i-1];
                    end
                end
            end
        end else if (i_cmd.step) begin
            // rotate the used cells left by one; a full dump restores order
            for (int i = 0; i < ENTRIES; i++) begin
                if (CW'(i) == last_idx) begin
                    n_keys[i]   = r_keys[0];
                    n_counts[i] = r_counts[0];
                end else if (CW'(i) < last_idx && i < ENTRIES - 1) begin
                    n_keys[i]   = r_keys[i+1];
                    n_counts[i] = r_counts[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            r_keys[i]   <= n_keys[i];
            r_counts[i] <= n_counts[i];
        end
        if (i_cmd.load) begin
            r_act <= i_action;
            r_key <= i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_used <= n_used;
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.exec) begin
                r_idx   <= '0;
                r_okey  <= r_key;
                r_olast <= 1'b1;
                case (r_act)
                    kft_pkg::ACT_COUNT: begin
                        r_ov <= 1'b1;
                        if (hit) begin
                            r_ocnt <= inc_cnt;
                            r_ost  <= kft_pkg::ST_OK;
                        end else if (r_used == FULL) begin
                            r_ocnt <= '0;
                            r_ost  <= kft_pkg::ST_DROPPED;
                        end else begin
                            r_ocnt <= kft_pkg::COUNT_W'(1);
                            r_ost  <= kft_pkg::ST_OK;
                        end
                    end
                    kft_pkg::ACT_QUERY: begin
                        r_ov   <= 1'b1;
                        r_ocnt <= hit ? hit_cnt : '0;
                        r_ost  <= hit ? kft_pkg::ST_OK : kft_pkg::ST_ABSENT;
                    end
                    kft_pkg::ACT_DUMP: begin
                        if (r_used == '0) begin
                            r_ov   <= 1'b1;
                            r_okey <= '0;
                            r_ocnt <= '0;
                            r_ost  <= kft_pkg::ST_EMPTY;
                        end
                    end
                    default: ;
                endcase
            end else if (i_cmd.step) begin
                r_ov    <= 1'b1;
                r_okey  <= r_keys[0];
                r_ocnt  <= r_counts[0];
                r_ost   <= kft_pkg::ST_OK;
                r_olast <= (r_idx == last_idx);
                r_idx   <= r_idx + 1'b1;
            end
        end
    end

    assign o_sts.out_free  = out_free;
    assign o_sts.is_dump   = (r_act == kft_pkg::ACT_DUMP);
    assign o_sts.used_zero = (r_used == '0);
    assign o_sts.dump_last = (r_idx == last_idx);
    assign o_sts.used_over = (r_used > FULL);

    assign o_valid   = r_ov;
    assign o_out_key = r_okey;
    assign o_count   = r_ocnt;
    assign o_status  = r_ost;
    assign o_last    = r_olast;

endmodule

FILE: tb/kft_checker.sv
`timescale 1ns / 1ps
module kft_checker #(
    parameter int ENTRIES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [1:0]                       i_action,
    input  logic signed [kft_pkg::KEY_W-1:0] i_key,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic signed [kft_pkg::KEY_W-1:0] i_out_key,
    input  logic [kft_pkg::COUNT_W-1:0]      i_count,
    input  logic [1:0]                       i_status,
    input  logic                             i_last,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam logic [kft_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic signed [kft_pkg::KEY_W-1:0] key;
        logic [kft_pkg::COUNT_W-1:0]      count;
        logic [1:0]                       status;
        logic                             last;
    } t_freq_result;

    // shadow copy of the sorted table
    logic signed [kft_pkg::KEY_W-1:0] shadow_keys [ENTRIES];
    logic [kft_pkg::COUNT_W-1:0]      shadow_counts [ENTRIES];
    int                               shadow_used = 0;

    t_freq_result expected_results [$];
    t_freq_result want;
    int           mismatches   = 0;
    int           results_seen = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic t_freq_result freq_result(
        input logic signed [kft_pkg::KEY_W-1:0] key,
        input logic [kft_pkg::COUNT_W-1:0] count,
        input logic [1:0] status,
        input logic last);
        t_freq_result r;
        r.key    = key;
        r.count  = count;
        r.status = status;
        r.last   = last;
        return r;
    endfunction

    // first slot whose key is not below the given key
    task automatic find_slot(input logic signed [kft_pkg::KEY_W-1:0] key, output int slot,
                             output bit hit);
        slot = 0;
        while (slot < shadow_used && shadow_keys[slot] < key) slot++;
        hit = (slot < shadow_used) && (shadow_keys[slot] == key);
    endtask

    task automatic predict_counts(input logic [1:0] action,
                                  input logic signed [kft_pkg::KEY_W-1:0] key);
        int slot;
        bit hit;
        case (action)
            kft_pkg::ACT_COUNT: begin
                find_slot(key, slot, hit);
                if (hit) begin
                    if (shadow_counts[slot] != COUNT_MAX) shadow_counts[slot]++;
                    expected_results.push_back(freq_result(key, shadow_counts[slot],
                                                           kft_pkg::ST_OK, 1'b1));
                end else if (shadow_used >= ENTRIES) begin
                    expected_results.push_back(freq_result(key, '0, kft_pkg::ST_DROPPED,
                                                           1'b1));
                end else begin
                    for (int j = shadow_used; j > slot; j--) begin
                        shadow_keys[j]   = shadow_keys[j-1];
                        shadow_counts[j] = shadow_counts[j-1];
                    end
                    shadow_keys[slot]   = key;
                    shadow_counts[slot] = kft_pkg::COUNT_W'(1);
                    shadow_used++;
                    expected_results.push_back(freq_result(key, kft_pkg::COUNT_W'(1),
                                                           kft_pkg::ST_OK, 1'b1));
                end
            end
            kft_pkg::ACT_QUERY: begin
                find_slot(key, slot, hit);
                if (hit) begin
                    expected_results.push_back(freq_result(key, shadow_counts[slot],
                                                           kft_pkg::ST_OK, 1'b1));
                end else begin
                    expected_results.push_back(freq_result(key, '0, kft_pkg::ST_ABSENT,
                                                           1'b1));
                end
            end
            kft_pkg::ACT_DUMP: begin
                if (shadow_used == 0) begin
                    expected_results.push_back(freq_result('0, '0, kft_pkg::ST_EMPTY,
                                                           1'b1));
                end else begin
                    for (int j = 0; j < shadow_used; j++) begin
                        expected_results.push_back(freq_result(shadow_keys[j],
                            shadow_counts[j], kft_pkg::ST_OK, j == shadow_used - 1));
                    end
                end
            end
            default: ;  // unused code: no result, table untouched
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_used = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d (key %0d) with nothing pending",
                                              results_seen, i_out_key));
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_key !== want.key)
                        report_mismatch($sformatf("result %0d key %0d, want %0d",
                                                  results_seen, i_out_key, want.key));
                    if (i_count !== want.count)
                        report_mismatch($sformatf("result %0d count %0d, want %0d",
                                                  results_seen, i_count, want.count));
                    if (i_status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                                  results_seen, i_status, want.status));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("result %0d last %0b, want %0b",
                                                  results_seen, i_last, want.last));
                end
                results_seen++;
            end
            if (i_in_valid && !i_in_stall) predict_counts(i_action, i_key);
        end
        o_pending <= expected_results.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam int ENTRIES      = 64;
    localparam int TAIL_CYCLES  = ENTRIES + 8;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int POOL_SIZE    = 96;
    localparam int REPEAT_ITEMS = 16;

    localparam logic [1:0]                       ACT_UNUSED = 2'd3;
    localparam logic signed [kft_pkg::KEY_W-1:0] KEY_MIN    = 32'sh8000_0000;
    localparam logic signed [kft_pkg::KEY_W-1:0] KEY_MAX    = 32'sh7FFF_FFFF;

    logic                             i_clk     = 1'b0;
    logic                             i_rst_n   = 1'b0;
    logic                             i_valid   = 1'b0;
    logic                             o_stall;
    logic [1:0]                       i_action  = kft_pkg::ACT_COUNT;
    logic signed [kft_pkg::KEY_W-1:0] i_key     = '0;
    logic                             o_valid;
    logic                             i_stall   = 1'b0;
    logic signed [kft_pkg::KEY_W-1:0] o_out_key;
    logic [kft_pkg::COUNT_W-1:0]      o_count;
    logic [1:0]                       o_status;
    logic                             o_last;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int hold_left   = 0;
    int burst_left  = 0;
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit hold_go     = 1'b0;
    bit hold_done   = 1'b0;

    logic signed [kft_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    key_frequency_table_core #(
        .ENTRIES(ENTRIES)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_action (i_action),
        .i_key    (i_key),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_out_key(o_out_key),
        .o_count  (o_count),
        .o_status (o_status),
        .o_last   (o_last)
    );

    kft_checker #(
        .ENTRIES(ENTRIES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_action    (i_action),
        .i_key       (i_key),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_key   (o_out_key),
        .i_count     (o_count),
        .i_status    (o_status),
        .i_last      (o_last),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: one long hold-off on request, otherwise short random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left <= burst_left - 1;
            i_stall    <= 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            burst_left <= $urandom_range(0, 4);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // offer one item and hold it until the block takes it
    task automatic send_item(input logic [1:0] action,
                             input logic signed [kft_pkg::KEY_W-1:0] key);
        int gap;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= action;
        i_key    <= key;
        do @(posedge i_clk); while (o_stall);
    endtask

    // mostly keys from a bounded pool so the table fills and keys repeat
    function automatic logic signed [kft_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    initial begin
        int sent;
        int roll;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(kft_pkg::ACT_DUMP, KEY_MAX);      // empty table
        send_item(kft_pkg::ACT_QUERY, '0);          // absent key
        send_item(kft_pkg::ACT_COUNT, KEY_MIN);
        send_item(kft_pkg::ACT_COUNT, KEY_MAX);
        send_item(kft_pkg::ACT_COUNT, '0);
        send_item(kft_pkg::ACT_COUNT, -1);
        send_item(kft_pkg::ACT_COUNT, 1);
        send_item(kft_pkg::ACT_COUNT, KEY_MAX);
        send_item(kft_pkg::ACT_COUNT, KEY_MIN + 1);
        send_item(kft_pkg::ACT_QUERY, KEY_MIN);
        send_item(kft_pkg::ACT_QUERY, -1);
        send_item(kft_pkg::ACT_QUERY, KEY_MAX - 1);
        send_item(ACT_UNUSED, -1);                  // ignored code
        send_item(kft_pkg::ACT_QUERY, KEY_MAX);
        send_item(kft_pkg::ACT_DUMP, '0);

        // one key back to back, flat out
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        repeat (REPEAT_ITEMS) send_item(kft_pkg::ACT_COUNT, 7);
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
        send_item(kft_pkg::ACT_QUERY, 7);
        send_item(kft_pkg::ACT_DUMP, -1);

        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = -1;
        key_pool[4] = 7;
        key_pool[5] = KEY_MIN + 1;
        key_pool[6] = KEY_MAX - 1;
        for (int p = 7; p < POOL_SIZE; p++) begin
            key_pool[p] = (p % 3 == 0) ? $signed($urandom_range(0, 40)) - 20
                                       : $signed($urandom);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == 100) hold_go <= 1'b1;
            if (sent == RANDOM_ITEMS * 3 / 4) begin
                tx_idle_on = 1'b0;
                rx_idle_on <= 1'b0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                send_item(kft_pkg::ACT_COUNT, pick_key());
                sent++;
            end else if (roll < 86) begin
                send_item(kft_pkg::ACT_QUERY, pick_key());
                sent++;
            end else if (roll < 95) begin
                send_item(kft_pkg::ACT_DUMP, $urandom);
                sent++;
            end else begin
                send_item(ACT_UNUSED, $urandom);
            end
        end
        send_item(kft_pkg::ACT_DUMP, '0);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
